[rtl/u8250_pkg.sv]
// Shared types and constants for the 8250 UART register block.
`default_nettype none

package u8250_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PUSH  = 2'd2;

    localparam logic [2:0] OFS_RBR_THR = 3'd0;
    localparam logic [2:0] OFS_IER     = 3'd1;
    localparam logic [2:0] OFS_IIR     = 3'd2;
    localparam logic [2:0] OFS_LCR     = 3'd3;
    localparam logic [2:0] OFS_MCR     = 3'd4;
    localparam logic [2:0] OFS_LSR     = 3'd5;
    localparam logic [2:0] OFS_MSR     = 3'd6;
    localparam logic [2:0] OFS_SCR     = 3'd7;

    localparam logic [7:0] LCR_DLAB  = 8'h80;
    localparam logic [7:0] IIR_RDA   = 8'h04;
    localparam logic [7:0] IIR_THRE  = 8'h02;
    localparam logic [7:0] IIR_NONE  = 8'h01;
    localparam logic [7:0] LSR_IDLE  = 8'h60;
    localparam logic [7:0] MSR_FIXED = 8'hB0;

    localparam logic [31:0] BASE_RESET = 32'h1000_0000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
        logic       pop;
    } resp_t;

endpackage

`default_nettype wire

[rtl/u8250_if.sv]
// Request and response channel interfaces for the 8250 UART register block.
`default_nettype none

interface u8250_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] address;
    logic [7:0]  write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, operation, address, write_data, rx_byte, input ready);
    modport sink   (input valid, operation, address, write_data, rx_byte, output ready);
endinterface

interface u8250_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;

    modport source (output valid, read_data, tx_valid, tx_byte, rx_dropped, input ready);
    modport sink   (input valid, read_data, tx_valid, tx_byte, rx_dropped, output ready);
endinterface

`default_nettype wire

[rtl/u8250_rx_ram.sv]
// Receive FIFO storage: one write port, one registered read port.
`default_nettype none

module u8250_rx_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/u8250_regs.sv]
// Register file, address decode and receive FIFO pointers.
`default_nettype none

module u8250_regs #(
    parameter int RX_DEPTH = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [1:0]    operation,
    input  wire logic [31:0]   address,
    input  wire logic [7:0]    write_data,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [31:0]   base,
    output u8250_pkg::resp_t   resp,
    output logic               ram_wr_en,
    output logic [AW-1:0]      ram_wr_addr,
    output logic [7:0]         ram_wr_data,
    output logic               ram_rd_en,
    output logic [AW-1:0]      ram_rd_addr
);

    localparam int SW = CW + 1;

    logic [7:0]    lcr_reg, lcr_next;
    logic [7:0]    dll_reg, dll_next;
    logic [7:0]    dlm_reg, dlm_next;
    logic [7:0]    ier_reg, ier_next;
    logic [7:0]    mcr_reg, mcr_next;
    logic [7:0]    scr_reg, scr_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    logic [31:0]   offset;
    logic          in_range;
    logic [2:0]    idx;
    logic          dlab;
    logic          not_empty;
    logic          full;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic          do_pop;
    logic          do_push;

    assign offset    = address - base;
    assign in_range  = (offset[31:3] == '0);
    assign idx       = offset[2:0];
    assign dlab      = (lcr_reg & u8250_pkg::LCR_DLAB) != 8'h00;
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CW'(RX_DEPTH));
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail      = (tail_sum >= SW'(RX_DEPTH)) ? AW'(tail_sum - SW'(RX_DEPTH))
                                                   : AW'(tail_sum);

    always_comb
    begin
        lcr_next = lcr_reg;
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        ier_next = ier_reg;
        mcr_next = mcr_reg;
        scr_next = scr_reg;
        resp     = '0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        case (operation)
            u8250_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    case (idx)
                        u8250_pkg::OFS_RBR_THR:
                        begin
                            if (dlab)
                            begin
                                resp.read_data = dll_reg;
                            end
                            else if (not_empty)
                            begin
                                do_pop   = 1'b1;
                                resp.pop = 1'b1;
                            end
                        end
                        u8250_pkg::OFS_IER: resp.read_data = dlab ? dlm_reg : ier_reg;
                        u8250_pkg::OFS_IIR:
                        begin
                            if (ier_reg[0] && not_empty)
                            begin
                                resp.read_data = u8250_pkg::IIR_RDA;
                            end
                            else if (ier_reg[1])
                            begin
                                resp.read_data = u8250_pkg::IIR_THRE;
                            end
                            else
                            begin
                                resp.read_data = u8250_pkg::IIR_NONE;
                            end
                        end
                        u8250_pkg::OFS_LCR: resp.read_data = lcr_reg;
                        u8250_pkg::OFS_MCR: resp.read_data = mcr_reg;
                        u8250_pkg::OFS_LSR: resp.read_data = u8250_pkg::LSR_IDLE
                                                             | {7'd0, not_empty};
                        u8250_pkg::OFS_MSR: resp.read_data = u8250_pkg::MSR_FIXED;
                        u8250_pkg::OFS_SCR: resp.read_data = scr_reg;
                        default:            resp.read_data = 8'h00;
                    endcase
                end
            end
            u8250_pkg::OP_WRITE:
            begin
                if (in_range)
                begin
                    case (idx)
                        u8250_pkg::OFS_RBR_THR:
                        begin
                            if (dlab)
                            begin
                                dll_next = write_data;
                            end
                            else
                            begin
                                resp.tx_valid = 1'b1;
                                resp.tx_byte  = write_data;
                            end
                        end
                        u8250_pkg::OFS_IER:
                        begin
                            if (dlab)
                            begin
                                dlm_next = write_data;
                            end
                            else
                            begin
                                ier_next = write_data;
                            end
                        end
                        u8250_pkg::OFS_LCR: lcr_next = write_data;
                        u8250_pkg::OFS_MCR: mcr_next = write_data;
                        u8250_pkg::OFS_SCR: scr_next = write_data;
                        default:            lcr_next = lcr_reg;
                    endcase
                end
            end
            u8250_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    resp.rx_dropped = 1'b1;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            default: resp = '0;
        endcase
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (accept && do_pop)
        begin
            head_next  = (head_reg == AW'(RX_DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
        else if (accept && do_push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    assign ram_wr_en   = accept && do_push;
    assign ram_wr_addr = tail;
    assign ram_wr_data = rx_byte;
    assign ram_rd_en   = accept && do_pop;
    assign ram_rd_addr = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcr_reg   <= '0;
            dll_reg   <= '0;
            dlm_reg   <= '0;
            ier_reg   <= '0;
            mcr_reg   <= '0;
            scr_reg   <= '0;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (accept)
            begin
                lcr_reg <= lcr_next;
                dll_reg <= dll_next;
                dlm_reg <= dlm_next;
                ier_reg <= ier_next;
                mcr_reg <= mcr_next;
                scr_reg <= scr_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/uart_8250_register_model.sv]
// Top level of the 8250 UART register block.
// The result is valid in the cycle after the request transaction is accepted.
// Throughput: one transaction per cycle; the output register takes a new
// result whenever it is empty or being drained in the same cycle.
// Received bytes sit in a RAM with a registered read port; a pop reads it at accept.
// Reset clears the UART registers, FIFO pointers and output valid flag, and sets base to 0x10000000.
`default_nettype none

module uart_8250_register_model #(
    parameter int RX_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    u8250_req_if.sink        req,
    u8250_rsp_if.source      rsp,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CW = $clog2(RX_DEPTH + 1);

    logic [31:0]       base_reg;
    logic              out_valid_reg;
    u8250_pkg::resp_t  out_reg;
    u8250_pkg::resp_t  resp;
    logic              accept;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [7:0]        ram_rd_data;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    u8250_regs #(
        .RX_DEPTH (RX_DEPTH),
        .AW       (AW),
        .CW       (CW)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (req.operation),
        .address     (req.address),
        .write_data  (req.write_data),
        .rx_byte     (req.rx_byte),
        .base        (base_reg),
        .resp        (resp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr)
    );

    u8250_rx_ram #(
        .DEPTH (RX_DEPTH),
        .AW    (AW)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= u8250_pkg::BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= resp;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_reg.pop ? ram_rd_data : out_reg.read_data;
    assign rsp.tx_valid   = out_reg.tx_valid;
    assign rsp.tx_byte    = out_reg.tx_byte;
    assign rsp.rx_dropped = out_reg.rx_dropped;

endmodule

`default_nettype wire
